>>> hw/rtl/b64e_pkg.sv
// shared types, constants and the character table for the base64 encoder
// no dependencies
package b64e_pkg;

  localparam int unsigned JobDepth = 2;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);

  localparam logic [7:0] PadChar = 8'h3D;

  typedef enum logic [1:0] {
    PH_GROUP0 = 2'd0,
    PH_GROUP1 = 2'd1,
    PH_GROUP2 = 2'd2
  } phase_e;

  typedef struct packed {
    logic       pad;
    logic [5:0] val;
  } sym_t;

  typedef struct packed {
    sym_t [3:0] sym;
    logic [1:0] last_idx;
    logic       fin;
  } job_t;

  function automatic logic [7:0] to_ascii(sym_t s);
    logic [7:0] v;
    logic [7:0] r;
    v = {2'b00, s.val};
    if (s.pad) begin
      r = PadChar;
    end else if (v < 8'd26) begin
      r = 8'h41 + v;
    end else if (v < 8'd52) begin
      r = 8'h61 + (v - 8'd26);
    end else if (v < 8'd62) begin
      r = 8'h30 + (v - 8'd52);
    end else if (v == 8'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/b64e_front.sv
// front end: takes message bytes, tracks group phase and leftover bits,
// builds one character job per byte; uses b64e_pkg
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              final_byte_i,
  output b64e_pkg::job_t    job_o
);

  b64e_pkg::phase_e phase_q, phase_d;
  logic [3:0]       pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64e_pkg::PH_GROUP0;
      pend_q  <= 4'd0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    pend_d  = pend_q;
    job_o   = '0;
    job_o.fin = final_byte_i;
    unique case (phase_q)
      b64e_pkg::PH_GROUP1: begin
        job_o.sym[0].val = {pend_q[1:0], data_byte_i[7:4]};
        job_o.sym[1].val = {data_byte_i[3:0], 2'b00};
        job_o.sym[2].pad = 1'b1;
        job_o.last_idx   = final_byte_i ? 2'd2 : 2'd0;
        if (accept_i) begin
          phase_d = b64e_pkg::PH_GROUP2;
          pend_d  = data_byte_i[3:0];
        end
      end
      b64e_pkg::PH_GROUP2: begin
        job_o.sym[0].val = {pend_q, data_byte_i[7:6]};
        job_o.sym[1].val = data_byte_i[5:0];
        job_o.last_idx   = 2'd1;
        if (accept_i) begin
          phase_d = b64e_pkg::PH_GROUP0;
          pend_d  = 4'd0;
        end
      end
      default: begin
        job_o.sym[0].val = data_byte_i[7:2];
        job_o.sym[1].val = {data_byte_i[1:0], 4'b0000};
        job_o.sym[2].pad = 1'b1;
        job_o.sym[3].pad = 1'b1;
        job_o.last_idx   = final_byte_i ? 2'd3 : 2'd0;
        if (accept_i) begin
          phase_d = b64e_pkg::PH_GROUP1;
          pend_d  = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
    if (accept_i && final_byte_i) begin
      phase_d = b64e_pkg::PH_GROUP0;
      pend_d  = 4'd0;
    end
  end

endmodule

>>> hw/rtl/b64e_fifo.sv
// short job queue between front and back end
// uses b64e_pkg for the job type and depth
module b64e_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  b64e_pkg::job_t wr_job_i,
  input  logic           rd_i,
  output b64e_pkg::job_t rd_job_o,
  output logic           full_o,
  output logic           empty_o
);

  b64e_pkg::job_t                  mem_q [b64e_pkg::JobDepth];
  logic [b64e_pkg::JobPtrW-1:0]    wp_q, rp_q;
  logic [b64e_pkg::JobCntW-1:0]    cnt_q;
  logic                            do_wr, do_rd;

  assign full_o   = (cnt_q == b64e_pkg::JobCntW'(b64e_pkg::JobDepth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == b64e_pkg::JobPtrW'(b64e_pkg::JobDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == b64e_pkg::JobPtrW'(b64e_pkg::JobDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/b64e_back.sv
// back end: walks the characters of each job and fills the output register
// uses b64e_pkg for the job type and the character table
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  b64e_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     text_char_o,
  output logic           run_end_o,
  output logic           message_end_o
);

  logic       valid_q;
  logic [1:0] idx_q, idx_d;
  logic [7:0] char_q;
  logic       run_end_q, msg_end_q;
  logic       load, last;

  assign load      = !job_empty_i && (!valid_q || pop_i);
  assign last      = (idx_q == job_i.last_idx);
  assign job_pop_o = load && last;
  assign idx_d     = last ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q    <= b64e_pkg::to_ascii(job_i.sym[idx_q]);
      run_end_q <= last;
      msg_end_q <= last && job_i.fin;
    end
  end

  assign empty_o       = !valid_q;
  assign text_char_o   = char_q;
  assign run_end_o     = run_end_q;
  assign message_end_o = msg_end_q;

endmodule

>>> hw/rtl/base64_stream_encoder_top.sv
// top level of the streaming base64 encoder
// instantiates b64e_front, b64e_fifo and b64e_back; uses b64e_pkg
//
// Bytes go in through a queue-style port (push/full) and base64 characters
// come out through another (empty/pop), one character per cycle while pop is
// held. Each byte turns into a job of one to four characters, built
// combinationally; a two-entry job queue sits in front of the character
// serializer, so the output rate of one character per clock, when pop keeps
// up, sets throughput: a byte causes one or two characters mid-group and up
// to four on a final byte, four per three bytes over a long message. A byte's
// job is written into the queue, then loaded into the output register once free.
module base64_stream_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] text_char_o,
  output logic       run_end_o,
  output logic       message_end_o
);

  b64e_pkg::job_t wr_job, rd_job;
  logic           accept, job_empty, job_pop;

  assign accept = push && !full;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .job_o        (wr_job)
  );

  b64e_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_job_i (wr_job),
    .rd_i     (job_pop),
    .rd_job_o (rd_job),
    .full_o   (full),
    .empty_o  (job_empty)
  );

  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_empty_i   (job_empty),
    .job_i         (rd_job),
    .job_pop_o     (job_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .text_char_o   (text_char_o),
    .run_end_o     (run_end_o),
    .message_end_o (message_end_o)
  );

endmodule
